/* rtl/u8v_pkg.sv */
// ----------------------------------------------------------------------------
// u8v_pkg
// Shared constants for the UTF-8 stream validator: byte class limits,
// register widths and the layout of the result side-band bits.
// ----------------------------------------------------------------------------
package u8v_pkg;

  // widths fixed by the stream format
  localparam int unsigned BYTE_BITS      = 8;
  localparam int unsigned BUDGET_BITS    = 16;
  localparam int unsigned FAULT_POS_BITS = 16;
  localparam int unsigned DUE_BITS       = 2;

  // default width of the position counters
  localparam int unsigned POSITION_BITS_DEF = 16;

  // byte budget after reset
  localparam logic [BUDGET_BITS-1:0] BUDGET_RESET = 16'hFFFF;

  // byte class limits
  localparam logic [BYTE_BITS-1:0] ASCII_LIMIT = 8'h80;  // first non-ascii byte
  localparam logic [BYTE_BITS-1:0] LEAD2_MAX   = 8'hDF;  // last 2-byte lead
  localparam logic [BYTE_BITS-1:0] LEAD3_MAX   = 8'hEF;  // last 3-byte lead
  localparam logic [BYTE_BITS-1:0] LEAD4_MAX   = 8'hF7;  // last 4-byte lead
  localparam logic [BYTE_BITS-1:0] CONT_MASK   = 8'hC0;  // continuation check mask
  localparam logic [BYTE_BITS-1:0] CONT_TAG    = 8'h80;  // continuation pattern
  localparam logic [BYTE_BITS-1:0] NUL_BYTE    = 8'h00;

  // continuations due after a lead
  localparam logic [DUE_BITS-1:0] DUE_NONE = 2'd0;
  localparam logic [DUE_BITS-1:0] DUE_ONE  = 2'd1;
  localparam logic [DUE_BITS-1:0] DUE_TWO  = 2'd2;
  localparam logic [DUE_BITS-1:0] DUE_THREE = 2'd3;

  // result tuser bit positions
  localparam int unsigned OUT_USER_BITS   = 4;
  localparam int unsigned USR_FINISHED    = 0;
  localparam int unsigned USR_VALID_RES   = 1;
  localparam int unsigned USR_ALL_ASCII   = 2;
  localparam int unsigned USR_FAULT_VALID = 3;

endpackage

/* rtl/utf8_stream_validator.sv */
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Byte-serial lenient UTF-8 framing check with verdict, ascii flag and
// position of the last multibyte lead on failure.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle and every accepted byte yields exactly one
// result transaction, in the next cycle, from a result register. The scan
// state is updated by combinational logic on each accepted byte, so the
// input keeps taking a byte per cycle as long as the result side takes its
// transactions; when the result side stalls, in_tready drops until the held
// result is taken. Setting the tuser bit of a byte starts a new string. Once a
// verdict is settled (NUL at a sequence boundary, byte budget reached, or a
// framing fault) it is repeated with finished set until the next string. The
// user writes the byte budget via cfg_wr_en/cfg_wr_data while idle (unenforced).
module utf8_stream_validator #(
  parameter int unsigned POSITION_BITS = u8v_pkg::POSITION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_wr_en,
  input  logic [u8v_pkg::BUDGET_BITS-1:0]    cfg_wr_data,    // byte_budget
  // byte stream in
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [u8v_pkg::BYTE_BITS-1:0]      in_tdata,       // [7:0] data_byte
  input  logic [0:0]                         in_tuser,       // [0] first_byte
  // result stream out
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [u8v_pkg::FAULT_POS_BITS-1:0] out_tdata,      // [15:0] fault_pos
  output logic [u8v_pkg::OUT_USER_BITS-1:0]  out_tuser       // [0] finished,
                                                             // [1] valid_res,
                                                             // [2] all_ascii,
                                                             // [3] fault_pos_valid
);

  localparam int unsigned CMP_W = ((POSITION_BITS > u8v_pkg::BUDGET_BITS) ?
                                   POSITION_BITS : u8v_pkg::BUDGET_BITS) + 2;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  // configuration and scan state
  logic [u8v_pkg::BUDGET_BITS-1:0] budget_r;
  logic [u8v_pkg::DUE_BITS-1:0]    due_r,   due_nxt;
  logic                            ascii_r, ascii_nxt;
  logic [POSITION_BITS-1:0]        pos_r,   pos_nxt;
  logic [POSITION_BITS-1:0]        lead_r,  lead_nxt;
  logic                            seen_r,  seen_nxt;
  logic                            done_r,  done_nxt;
  logic                            ok_r,    ok_nxt;

  // result register
  logic                                out_valid_r;
  logic [u8v_pkg::FAULT_POS_BITS-1:0]  out_pos_r, out_pos_nxt;
  logic [u8v_pkg::OUT_USER_BITS-1:0]   out_user_r, out_user_nxt;

  logic                        in_acc;
  logic                        first;
  logic [u8v_pkg::BYTE_BITS-1:0] b;
  logic [CMP_W-1:0]            count_w;
  logic [CMP_W-1:0]            budget_w;
  logic [CMP_W-1:0]            need_w;
  logic [u8v_pkg::DUE_BITS-1:0] lead_due;
  logic [u8v_pkg::DUE_BITS-1:0] due_dec;
  logic                        bad;
  logic [CMP_W-1:0]            lead_ext;

  // handshake
  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pos_r;
  assign out_tuser  = out_user_r;

  assign first = in_tuser[0];
  assign b     = in_tdata;

  // next scan state for the byte at the input
  always_comb begin
    // a new string starts from a clean scan
    if (first) begin
      due_nxt   = u8v_pkg::DUE_NONE;
      ascii_nxt = 1'b1;
      pos_nxt   = '0;
      lead_nxt  = '0;
      seen_nxt  = 1'b0;
      done_nxt  = 1'b0;
      ok_nxt    = 1'b1;
    end else begin
      due_nxt   = due_r;
      ascii_nxt = ascii_r;
      pos_nxt   = pos_r;
      lead_nxt  = lead_r;
      seen_nxt  = seen_r;
      done_nxt  = done_r;
      ok_nxt    = ok_r;
    end

    count_w  = CMP_W'(pos_nxt) + CMP_W'(1);
    budget_w = CMP_W'(budget_r);

    if (b <= u8v_pkg::LEAD2_MAX) begin
      lead_due = u8v_pkg::DUE_ONE;
    end else if (b <= u8v_pkg::LEAD3_MAX) begin
      lead_due = u8v_pkg::DUE_TWO;
    end else begin
      lead_due = u8v_pkg::DUE_THREE;
    end
    need_w  = count_w + CMP_W'(lead_due);
    due_dec = due_nxt - u8v_pkg::DUE_ONE;

    if (!done_nxt) begin
      if (due_nxt == u8v_pkg::DUE_NONE) begin
        // sequence boundary
        if (b == u8v_pkg::NUL_BYTE) begin
          done_nxt = 1'b1;
          ok_nxt   = 1'b1;
        end else if (b < u8v_pkg::ASCII_LIMIT) begin
          if (count_w >= budget_w) begin
            done_nxt = 1'b1;
            ok_nxt   = 1'b1;
          end
        end else begin
          ascii_nxt = 1'b0;
          lead_nxt  = pos_nxt;
          seen_nxt  = 1'b1;
          if (b > u8v_pkg::LEAD4_MAX) begin
            done_nxt = 1'b1;
            ok_nxt   = 1'b0;
          end else if (need_w > budget_w && need_w > CMP_W'(1)) begin
            // sequence would run past the budget
            done_nxt = 1'b1;
            ok_nxt   = 1'b0;
          end else begin
            due_nxt = lead_due;
          end
        end
      end else begin
        // inside a sequence
        if ((b & u8v_pkg::CONT_MASK) != u8v_pkg::CONT_TAG) begin
          done_nxt = 1'b1;
          ok_nxt   = 1'b0;
        end else begin
          due_nxt = due_dec;
          if (due_dec == u8v_pkg::DUE_NONE && count_w >= budget_w) begin
            done_nxt = 1'b1;
            ok_nxt   = 1'b1;
          end
        end
      end
      // saturating byte count
      if (pos_nxt != POS_MAX) begin
        pos_nxt = pos_nxt + POSITION_BITS'(1);
      end
    end

    // result fields from the updated state
    bad      = done_nxt && !ok_nxt;
    lead_ext = CMP_W'(lead_nxt);
    out_user_nxt = '0;
    out_user_nxt[u8v_pkg::USR_FINISHED]    = done_nxt;
    out_user_nxt[u8v_pkg::USR_VALID_RES]   = !bad;
    out_user_nxt[u8v_pkg::USR_ALL_ASCII]   = ascii_nxt;
    out_user_nxt[u8v_pkg::USR_FAULT_VALID] = bad && seen_nxt;
    out_pos_nxt = (bad && seen_nxt) ? lead_ext[u8v_pkg::FAULT_POS_BITS-1:0] : '0;
  end

  // state, configuration and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r    <= u8v_pkg::BUDGET_RESET;
      due_r       <= u8v_pkg::DUE_NONE;
      ascii_r     <= 1'b1;
      pos_r       <= '0;
      lead_r      <= '0;
      seen_r      <= 1'b0;
      done_r      <= 1'b0;
      ok_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        budget_r <= cfg_wr_data;
      end
      if (in_acc) begin
        due_r       <= due_nxt;
        ascii_r     <= ascii_nxt;
        pos_r       <= pos_nxt;
        lead_r      <= lead_nxt;
        seen_r      <= seen_nxt;
        done_r      <= done_nxt;
        ok_r        <= ok_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each transaction
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_pos_r  <= out_pos_nxt;
      out_user_r <= out_user_nxt;
    end
  end

endmodule

/* rtl/u8v_checker.sv */
// ----------------------------------------------------------------------------
// u8v_checker
// Port-level checks for the UTF-8 stream validator, bound to the top level.
// ----------------------------------------------------------------------------
module u8v_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [u8v_pkg::FAULT_POS_BITS-1:0] out_tdata,
  input logic [u8v_pkg::OUT_USER_BITS-1:0]  out_tuser
);

  // held result keeps its payload while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // input only stalls behind a stalled result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back-pressure");

  // every accepted byte shows up as a result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted byte produced no result");

  // a fault position only comes with a settled invalid verdict
  a_fault_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[u8v_pkg::USR_FAULT_VALID] |->
      out_tuser[u8v_pkg::USR_FINISHED] && !out_tuser[u8v_pkg::USR_VALID_RES])
    else $error("fault position without invalid verdict");

  // fault position reads zero when not flagged
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[u8v_pkg::USR_FAULT_VALID] |-> out_tdata == '0)
    else $error("fault position nonzero without fault");

endmodule

bind utf8_stream_validator u8v_checker u_u8v_checker (.*);
